>>> src/lightcone_shell_crossing_defines.svh
// assertion macros for the lightcone shell crossing block
// used by the top level; expects aclk and aresetn in scope
`ifndef LIGHTCONE_SHELL_CROSSING_DEFINES_SVH
`define LIGHTCONE_SHELL_CROSSING_DEFINES_SVH

// same-cycle implication, disabled in reset
`define LSC_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define LSC_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/lsc_pkg.sv
// shared types, constants and step functions for the shell crossing block
// no dependencies
`timescale 1ns / 1ps

package lsc_pkg;

    localparam int FRAC_BITS  = 24;
    localparam int MAX_IMAGE  = 64;
    localparam int IMG_W      = 7;
    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = FRAC_BITS + 1;

    localparam logic signed [25:0] ONE_S  = 26'sd1 <<< FRAC_BITS;
    localparam logic signed [25:0] HALF_S = 26'sd1 <<< (FRAC_BITS - 1);
    localparam logic [24:0]        ONE_Q  = 25'd1 << FRAC_BITS;
    localparam logic [50:0]        HALF_P = 51'd1 << (FRAC_BITS - 1);
    localparam logic [57:0]        HALF_Z = 58'd1 << (FRAC_BITS - 1);

    typedef enum logic [2:0] {
        REG_PREV_RADIUS   = 3'd0,
        REG_CUR_RADIUS    = 3'd1,
        REG_PREV_REDSHIFT = 3'd2,
        REG_CUR_REDSHIFT  = 3'd3
    } cfg_reg_t;

    // one square-root lane: radicand shifting out, partial remainder and root
    typedef struct packed {
        logic [63:0] rad;
        logic [32:0] rem;
        logic [31:0] root;
    } sqrt_lane_t;

    typedef struct packed {
        sqrt_lane_t cur;
        sqrt_lane_t prv;
    } sqrt_pair_t;

    // one divider lane: divisor, partial remainder, quotient, dividend bits
    typedef struct packed {
        logic [32:0] den;
        logic [32:0] rem;
        logic [24:0] quo;
        logic [24:0] dvd;
    } div_lane_t;

    // path data that rides along with each word
    typedef struct packed {
        logic signed [31:0] pb_x;
        logic signed [31:0] pb_y;
        logic signed [31:0] pb_z;
        logic signed [24:0] d_x;
        logic signed [24:0] d_y;
        logic signed [24:0] d_z;
        logic               crossed;
    } geo_t;

    typedef struct packed {
        logic signed [31:0] p;
        logic signed [31:0] pb;
        logic signed [24:0] d;
    } axis_t;

    // periodic unwrap of one axis and placement of the image
    function automatic axis_t place_axis(logic [23:0] now_v, logic [23:0] bef_v,
                                         logic signed [6:0] img);
        axis_t              a;
        int                 iv;
        logic signed [6:0]  ic;
        logic signed [31:0] off;
        logic signed [25:0] diff;
        logic signed [25:0] bef_u;
        iv = int'(img);
        if (iv < -MAX_IMAGE) iv = -MAX_IMAGE;
        if (iv > MAX_IMAGE - 1) iv = MAX_IMAGE - 1;
        ic = 7'(iv);
        off = {{(32 - IMG_W - FRAC_BITS){ic[IMG_W-1]}}, ic, {FRAC_BITS{1'b0}}};
        diff = $signed({2'b00, now_v}) - $signed({2'b00, bef_v});
        bef_u = $signed({2'b00, bef_v});
        if (diff < -HALF_S) begin
            bef_u = bef_u - ONE_S;
        end else if (diff > HALF_S) begin
            bef_u = bef_u + ONE_S;
        end
        a.d  = 25'($signed({2'b00, now_v}) - bef_u);
        a.p  = $signed({8'd0, now_v}) + off;
        a.pb = 32'(bef_u) + off;
        return a;
    endfunction

    function automatic logic [30:0] mag31(logic signed [31:0] v);
        return v[31] ? 31'(-v) : 31'(v);
    endfunction

    // one root bit: bring down two radicand bits, try root*4+1
    function automatic sqrt_lane_t sqrt_step(sqrt_lane_t l);
        sqrt_lane_t  o;
        logic [34:0] r2;
        logic [34:0] trial;
        r2    = {l.rem[32:0], l.rad[63:62]};
        trial = {1'b0, l.root, 2'b01};
        o.rad = {l.rad[61:0], 2'b00};
        if (r2 >= trial) begin
            o.rem  = 33'(r2 - trial);
            o.root = {l.root[30:0], 1'b1};
        end else begin
            o.rem  = r2[32:0];
            o.root = {l.root[30:0], 1'b0};
        end
        return o;
    endfunction

    // one quotient bit of restoring division
    function automatic div_lane_t div_step(div_lane_t l);
        div_lane_t   o;
        logic [33:0] r2;
        r2    = {l.rem, l.dvd[24]};
        o.den = l.den;
        o.dvd = {l.dvd[23:0], 1'b0};
        if (r2 >= {1'b0, l.den}) begin
            o.rem = 33'(r2 - {1'b0, l.den});
            o.quo = {l.quo[23:0], 1'b1};
        end else begin
            o.rem = r2[32:0];
            o.quo = {l.quo[23:0], 1'b0};
        end
        return o;
    endfunction

endpackage

>>> src/lsc_sqrt_cell.sv
// one cell of the square-root chain: one root bit for both distances
// depends on lsc_pkg
`timescale 1ns / 1ps

module lsc_sqrt_cell (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  lsc_pkg::sqrt_pair_t in_data,
    input  lsc_pkg::geo_t      in_geo,
    output logic               out_valid,
    input  logic               out_ready,
    output lsc_pkg::sqrt_pair_t out_data,
    output lsc_pkg::geo_t      out_geo
);
    import lsc_pkg::*;

    logic       valid_reg;
    sqrt_pair_t data_reg;
    geo_t       geo_reg;

    assign in_ready = !valid_reg || out_ready;

    // valid bit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    // root step on both lanes
    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg.cur <= sqrt_step(in_data.cur);
            data_reg.prv <= sqrt_step(in_data.prv);
            geo_reg      <= in_geo;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
    assign out_geo   = geo_reg;

endmodule

>>> src/lsc_div_cell.sv
// one cell of the divider chain: one bit of the interpolation factor
// depends on lsc_pkg
`timescale 1ns / 1ps

module lsc_div_cell (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  lsc_pkg::div_lane_t in_data,
    input  lsc_pkg::geo_t     in_geo,
    output logic              out_valid,
    input  logic              out_ready,
    output lsc_pkg::div_lane_t out_data,
    output lsc_pkg::geo_t     out_geo
);
    import lsc_pkg::*;

    logic      valid_reg;
    div_lane_t data_reg;
    geo_t      geo_reg;

    assign in_ready = !valid_reg || out_ready;

    // valid bit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    // quotient step
    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= div_step(in_data);
            geo_reg  <= in_geo;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
    assign out_geo   = geo_reg;

endmodule

>>> src/lightcone_shell_crossing.sv
// top level of the lightcone shell crossing block
// depends on lsc_pkg, lsc_sqrt_cell, lsc_div_cell and the assertion macro header
`timescale 1ns / 1ps
`include "lightcone_shell_crossing_defines.svh"

// Takes one particle/image word per cycle while the output side does not stall and
// returns one result word per input, in order. A word passes 63 register stages: unwrap
// and image placement settle in the accepting cycle into the entry stage, then a stage to
// square, one to sum, 32 square-root cells (one root bit each, both distances side by
// side), one to form the crossing test and divider operands, 25 divider cells (one
// factor bit each), one for the products and one to round, add and saturate into the
// output register. Every stage holds its own valid bit and fills bubbles, so a stalled
// output blocks the input only once every stage holds a word.
// The user must write radii and redshifts through the plain write port only while idle;
// the block itself does not enforce it.
module lightcone_shell_crossing (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [23:0] s_now_x,
    input  logic [23:0] s_now_y,
    input  logic [23:0] s_now_z,
    input  logic [23:0] s_before_x,
    input  logic [23:0] s_before_y,
    input  logic [23:0] s_before_z,
    input  logic signed [6:0] s_image_i,
    input  logic signed [6:0] s_image_j,
    input  logic signed [6:0] s_image_k,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_crossed,
    output logic signed [31:0] m_cross_x,
    output logic signed [31:0] m_cross_y,
    output logic signed [31:0] m_cross_z,
    output logic [31:0] m_cross_redshift
);
    import lsc_pkg::*;

    // configuration registers
    logic [31:0] prev_radius_reg, cur_radius_reg, prev_z_reg, cur_z_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_radius_reg <= '0;
            cur_radius_reg  <= '0;
            prev_z_reg      <= '0;
            cur_z_reg       <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_PREV_RADIUS:   prev_radius_reg <= cfg_data;
                REG_CUR_RADIUS:    cur_radius_reg  <= cfg_data;
                REG_PREV_REDSHIFT: prev_z_reg      <= cfg_data;
                REG_CUR_REDSHIFT:  cur_z_reg       <= cfg_data;
                default: ;
            endcase
        end
    end

    // stage a: unwrap and place the image
    axis_t ax_x, ax_y, ax_z;
    logic  a_valid_reg, a_ready;
    logic signed [31:0] a_p_reg [3];
    geo_t  a_geo_reg;

    assign ax_x = place_axis(s_now_x, s_before_x, s_image_i);
    assign ax_y = place_axis(s_now_y, s_before_y, s_image_j);
    assign ax_z = place_axis(s_now_z, s_before_z, s_image_k);
    assign s_ready = a_ready;

    logic b_ready;
    assign a_ready = !a_valid_reg || b_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (a_ready) begin
            a_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_ready && s_valid) begin
            a_p_reg[0]        <= ax_x.p;
            a_p_reg[1]        <= ax_y.p;
            a_p_reg[2]        <= ax_z.p;
            a_geo_reg.pb_x    <= ax_x.pb;
            a_geo_reg.pb_y    <= ax_y.pb;
            a_geo_reg.pb_z    <= ax_z.pb;
            a_geo_reg.d_x     <= ax_x.d;
            a_geo_reg.d_y     <= ax_y.d;
            a_geo_reg.d_z     <= ax_z.d;
            a_geo_reg.crossed <= 1'b0;
        end
    end

    // stage b: squares of the coordinate magnitudes
    logic        b_valid_reg;
    logic [61:0] b_sq_cur_reg [3];
    logic [61:0] b_sq_prv_reg [3];
    geo_t        b_geo_reg;
    logic        c_ready;

    assign b_ready = !b_valid_reg || c_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (b_ready) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (b_ready && a_valid_reg) begin
            b_sq_cur_reg[0] <= mag31(a_p_reg[0]) * mag31(a_p_reg[0]);
            b_sq_cur_reg[1] <= mag31(a_p_reg[1]) * mag31(a_p_reg[1]);
            b_sq_cur_reg[2] <= mag31(a_p_reg[2]) * mag31(a_p_reg[2]);
            b_sq_prv_reg[0] <= mag31(a_geo_reg.pb_x) * mag31(a_geo_reg.pb_x);
            b_sq_prv_reg[1] <= mag31(a_geo_reg.pb_y) * mag31(a_geo_reg.pb_y);
            b_sq_prv_reg[2] <= mag31(a_geo_reg.pb_z) * mag31(a_geo_reg.pb_z);
            b_geo_reg       <= a_geo_reg;
        end
    end

    // stage c: sums of squares seed the root chain
    logic       c_valid_reg;
    sqrt_pair_t c_data_reg;
    geo_t       c_geo_reg;

    logic       sq_valid [SQRT_STEPS+1];
    logic       sq_ready [SQRT_STEPS+1];
    sqrt_pair_t sq_data  [SQRT_STEPS+1];
    geo_t       sq_geo   [SQRT_STEPS+1];

    assign c_ready = !c_valid_reg || sq_ready[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else if (c_ready) begin
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (c_ready && b_valid_reg) begin
            c_data_reg.cur.rad  <= 64'(b_sq_cur_reg[0]) + 64'(b_sq_cur_reg[1])
                                 + 64'(b_sq_cur_reg[2]);
            c_data_reg.prv.rad  <= 64'(b_sq_prv_reg[0]) + 64'(b_sq_prv_reg[1])
                                 + 64'(b_sq_prv_reg[2]);
            c_data_reg.cur.rem  <= '0;
            c_data_reg.cur.root <= '0;
            c_data_reg.prv.rem  <= '0;
            c_data_reg.prv.root <= '0;
            c_geo_reg           <= b_geo_reg;
        end
    end

    assign sq_valid[0] = c_valid_reg;
    assign sq_data[0]  = c_data_reg;
    assign sq_geo[0]   = c_geo_reg;

    // square-root cell chain
    for (genvar gi = 0; gi < SQRT_STEPS; gi++) begin : g_sqrt
        lsc_sqrt_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (sq_valid[gi]),
            .in_ready  (sq_ready[gi]),
            .in_data   (sq_data[gi]),
            .in_geo    (sq_geo[gi]),
            .out_valid (sq_valid[gi+1]),
            .out_ready (sq_ready[gi+1]),
            .out_data  (sq_data[gi+1]),
            .out_geo   (sq_geo[gi+1])
        );
    end

    // stage d: crossing test and divider operands
    logic        d_valid_reg, d_ready;
    div_lane_t   d_div_reg;
    geo_t        d_geo_reg;
    geo_t        d_geo_in;
    logic [31:0] pr, prb, num;
    logic        cross_now;

    logic      dv_valid [DIV_STEPS+1];
    logic      dv_ready [DIV_STEPS+1];
    div_lane_t dv_data  [DIV_STEPS+1];
    geo_t      dv_geo   [DIV_STEPS+1];

    assign pr        = sq_data[SQRT_STEPS].cur.root;
    assign prb       = sq_data[SQRT_STEPS].prv.root;
    assign cross_now = (prb < prev_radius_reg) && (pr >= cur_radius_reg);
    assign num       = prev_radius_reg - prb;
    assign d_ready   = !d_valid_reg || dv_ready[0];
    assign sq_ready[SQRT_STEPS] = d_ready;

    // path data with the crossing flag filled in
    always_comb begin
        d_geo_in         = sq_geo[SQRT_STEPS];
        d_geo_in.crossed = cross_now;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_valid_reg <= 1'b0;
        end else if (d_ready) begin
            d_valid_reg <= sq_valid[SQRT_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (d_ready && sq_valid[SQRT_STEPS]) begin
            d_div_reg.den <= {1'b0, pr} - {1'b0, cur_radius_reg} + {1'b0, num};
            d_div_reg.rem <= {2'b00, num[31:1]};
            d_div_reg.dvd <= {num[0], {FRAC_BITS{1'b0}}};
            d_div_reg.quo <= '0;
            d_geo_reg     <= d_geo_in;
        end
    end

    assign dv_valid[0] = d_valid_reg;
    assign dv_data[0]  = d_div_reg;
    assign dv_geo[0]   = d_geo_reg;

    // divider cell chain
    for (genvar gj = 0; gj < DIV_STEPS; gj++) begin : g_div
        lsc_div_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (dv_valid[gj]),
            .in_ready  (dv_ready[gj]),
            .in_data   (dv_data[gj]),
            .in_geo    (dv_geo[gj]),
            .out_valid (dv_valid[gj+1]),
            .out_ready (dv_ready[gj+1]),
            .out_data  (dv_data[gj+1]),
            .out_geo   (dv_geo[gj+1])
        );
    end

    // stage e: factor times each difference
    logic               e_valid_reg, e_ready, f_ready;
    logic [49:0]        e_mx_reg, e_my_reg, e_mz_reg;
    logic [56:0]        e_mr_reg;
    logic               e_nx_reg, e_ny_reg, e_nz_reg, e_nr_reg;
    geo_t               e_geo_reg;
    logic [24:0]        fac;
    logic signed [32:0] zdiff;
    logic [31:0]        zmag;

    assign fac   = dv_data[DIV_STEPS].quo;
    assign zdiff = $signed({1'b0, cur_z_reg}) - $signed({1'b0, prev_z_reg});
    assign zmag  = zdiff[32] ? 32'(-zdiff) : 32'(zdiff);
    assign e_ready = !e_valid_reg || f_ready;
    assign dv_ready[DIV_STEPS] = e_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_valid_reg <= 1'b0;
        end else if (e_ready) begin
            e_valid_reg <= dv_valid[DIV_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (e_ready && dv_valid[DIV_STEPS]) begin
            e_mx_reg  <= fac * (dv_geo[DIV_STEPS].d_x[24] ? 25'(-dv_geo[DIV_STEPS].d_x)
                                                          : 25'(dv_geo[DIV_STEPS].d_x));
            e_my_reg  <= fac * (dv_geo[DIV_STEPS].d_y[24] ? 25'(-dv_geo[DIV_STEPS].d_y)
                                                          : 25'(dv_geo[DIV_STEPS].d_y));
            e_mz_reg  <= fac * (dv_geo[DIV_STEPS].d_z[24] ? 25'(-dv_geo[DIV_STEPS].d_z)
                                                          : 25'(dv_geo[DIV_STEPS].d_z));
            e_mr_reg  <= fac * zmag;
            e_nx_reg  <= dv_geo[DIV_STEPS].d_x[24];
            e_ny_reg  <= dv_geo[DIV_STEPS].d_y[24];
            e_nz_reg  <= dv_geo[DIV_STEPS].d_z[24];
            e_nr_reg  <= zdiff[32];
            e_geo_reg <= dv_geo[DIV_STEPS];
        end
    end

    // stage f: round, add to the start point, saturate
    logic               f_valid_reg, f_crossed_reg;
    logic signed [31:0] f_x_reg, f_y_reg, f_z_reg;
    logic [31:0]        f_r_reg;
    logic [50:0]        rnd_x, rnd_y, rnd_z;
    logic [57:0]        rnd_r;
    logic signed [35:0] sum_x, sum_y, sum_z, sum_r;

    function automatic logic signed [35:0] add_scaled(logic signed [31:0] base,
                                                      logic [50:0] rnd, logic neg);
        logic signed [35:0] s;
        s = $signed({9'd0, rnd[50:FRAC_BITS]});
        return 36'(base) + (neg ? -s : s);
    endfunction

    function automatic logic [31:0] sat_s32(logic signed [35:0] v);
        if (v > 36'sh07FFFFFFF) begin
            return 32'h7FFF_FFFF;
        end else if (v < -36'sh080000000) begin
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    assign rnd_x = {1'b0, e_mx_reg} + HALF_P;
    assign rnd_y = {1'b0, e_my_reg} + HALF_P;
    assign rnd_z = {1'b0, e_mz_reg} + HALF_P;
    assign rnd_r = {1'b0, e_mr_reg} + HALF_Z;
    assign sum_x = add_scaled(e_geo_reg.pb_x, rnd_x, e_nx_reg);
    assign sum_y = add_scaled(e_geo_reg.pb_y, rnd_y, e_ny_reg);
    assign sum_z = add_scaled(e_geo_reg.pb_z, rnd_z, e_nz_reg);
    assign sum_r = $signed({4'd0, prev_z_reg})
                 + (e_nr_reg ? -$signed({2'd0, rnd_r[57:FRAC_BITS]})
                             :  $signed({2'd0, rnd_r[57:FRAC_BITS]}));

    assign f_ready = !f_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
        end else if (f_ready) begin
            f_valid_reg <= e_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (f_ready && e_valid_reg) begin
            f_crossed_reg <= e_geo_reg.crossed;
            if (e_geo_reg.crossed) begin
                f_x_reg <= sat_s32(sum_x);
                f_y_reg <= sat_s32(sum_y);
                f_z_reg <= sat_s32(sum_z);
                if (sum_r[35]) begin
                    f_r_reg <= '0;
                end else if (sum_r[34:32] != 3'd0) begin
                    f_r_reg <= '1;
                end else begin
                    f_r_reg <= sum_r[31:0];
                end
            end else begin
                f_x_reg <= '0;
                f_y_reg <= '0;
                f_z_reg <= '0;
                f_r_reg <= '0;
            end
        end
    end

    assign m_valid          = f_valid_reg;
    assign m_crossed        = f_crossed_reg;
    assign m_cross_x        = f_x_reg;
    assign m_cross_y        = f_y_reg;
    assign m_cross_z        = f_z_reg;
    assign m_cross_redshift = f_r_reg;

    // checks on the datapath
    `LSC_ASSERT_NOW(a_clear_is_zero, m_valid && !m_crossed, m_cross_x == 0 && m_cross_y == 0 && m_cross_z == 0 && m_cross_redshift == 0, "non-crossing word carries data")
    `LSC_ASSERT_NOW(a_den_above_rem, d_valid_reg && d_geo_reg.crossed, d_div_reg.den > d_div_reg.rem, "divider seed not below divisor")
    `LSC_ASSERT_NOW(a_factor_range, dv_valid[DIV_STEPS] && dv_geo[DIV_STEPS].crossed, fac <= ONE_Q, "interpolation factor out of range")
    `LSC_ASSERT_NEXT(a_accept_loads, s_valid && s_ready, a_valid_reg, "accepted word lost at entry")

endmodule
